// File: rtl/bsc_pkg.sv
package bsc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 7;
    localparam int PROD_W   = SAMPLE_W + DUTY_W;

    localparam logic [DUTY_W-1:0]   START_LIMIT_RST = 7'd40;
    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL     = 10'd1023;

    localparam logic [2:0] HALL_STEP1 = 3'd5;
    localparam logic [2:0] HALL_STEP2 = 3'd1;
    localparam logic [2:0] HALL_STEP3 = 3'd3;
    localparam logic [2:0] HALL_STEP4 = 3'd2;
    localparam logic [2:0] HALL_STEP5 = 3'd6;
    localparam logic [2:0] HALL_STEP6 = 3'd4;

    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_A    = 2'd1;
    localparam logic [1:0] PHASE_B    = 2'd2;
    localparam logic [1:0] PHASE_C    = 2'd3;

    localparam logic [2:0] LINE_NONE = 3'b000;
    localparam logic [2:0] LINE_A    = 3'b001;
    localparam logic [2:0] LINE_B    = 3'b010;
    localparam logic [2:0] LINE_C    = 3'b100;

    typedef struct packed {
        logic       armed;
        logic [1:0] pwm_phase;
        logic [2:0] levels;
    } t_state;

    typedef struct packed {
        logic [2:0]        shutdown;
        logic [1:0]        pwm_phase;
        logic [2:0]        levels;
        logic [DUTY_W-1:0] duty;
        logic              armed;
    } t_result;

endpackage

// File: rtl/bsc_step.sv
module bsc_step (
    input  logic [2:0]                     i_hall,
    input  logic [bsc_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [bsc_pkg::DUTY_W-1:0]     i_start_limit,
    input  bsc_pkg::t_state                i_state,
    output bsc_pkg::t_result               o_result
);
    import bsc_pkg::*;

    logic [PROD_W-1:0]   w_prod;
    logic [DUTY_W-1:0]   w_q0;
    logic [SAMPLE_W:0]   w_rem;
    logic [DUTY_W-1:0]   w_duty;

    // Division by 1023 = 1024 - 1: the remainder after the shift stays below twice 1023.
    assign w_prod = {i_sample, {DUTY_W{1'b0}}} - {{DUTY_W{1'b0}}, i_sample};
    assign w_q0   = w_prod[PROD_W-1:SAMPLE_W];
    assign w_rem  = {1'b0, w_prod[SAMPLE_W-1:0]} + {{(SAMPLE_W+1-DUTY_W){1'b0}}, w_q0};
    assign w_duty = (w_rem >= {1'b0, SAMPLE_FULL}) ? w_q0 + 7'd1 : w_q0;

    always_comb begin
        o_result.shutdown  = LINE_NONE;
        o_result.pwm_phase = i_state.pwm_phase;
        o_result.levels    = i_state.levels;
        o_result.duty      = w_duty;
        o_result.armed     = i_state.armed;
        if (!i_state.armed) begin
            if (w_duty < i_start_limit) begin
                o_result.armed = 1'b1;
            end
        end else if (w_duty != '0) begin
            unique case (i_hall)
                HALL_STEP1: begin
                    o_result.shutdown  = LINE_A;
                    o_result.pwm_phase = PHASE_B;
                    o_result.levels    = LINE_B;
                end
                HALL_STEP2: begin
                    o_result.shutdown  = LINE_A;
                    o_result.pwm_phase = PHASE_C;
                    o_result.levels    = LINE_C;
                end
                HALL_STEP3: begin
                    o_result.shutdown  = LINE_B;
                    o_result.pwm_phase = PHASE_C;
                    o_result.levels    = LINE_C;
                end
                HALL_STEP4: begin
                    o_result.shutdown  = LINE_B;
                    o_result.pwm_phase = PHASE_A;
                    o_result.levels    = LINE_A;
                end
                HALL_STEP5: begin
                    o_result.shutdown  = LINE_C;
                    o_result.pwm_phase = PHASE_A;
                    o_result.levels    = LINE_A;
                end
                HALL_STEP6: begin
                    o_result.shutdown  = LINE_C;
                    o_result.pwm_phase = PHASE_B;
                    o_result.levels    = i_state.levels & LINE_B;
                end
                default: begin
                    o_result.shutdown  = LINE_NONE;
                end
            endcase
        end
    end

endmodule

// File: rtl/bldc_six_step_commutator_top.sv
// Hall-sensored six-step commutator. Each transfer on the slave stream is one control
// tick and yields exactly one result transfer on the master stream, passing through the
// input register, a single decode pass and the result register; one tick is accepted
// every clock cycle unless a stalled result register holds back the input register. The
// duty is floor(throttle*127/1023). After reset the shutdown lines stay cleared until a
// tick with duty below start_limit arms the block; that tick itself does not commutate.
// Write start_limit only while no ticks are in flight.
module bldc_six_step_commutator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: hall_bits[2:0], throttle_sample[12:3], zero fill[15:13].
    input  logic [15:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: shutdown_lines[2:0], pwm_phase[4:3], input_levels[7:5],
    // duty[14:8], armed[15].
    output logic [15:0] o_m_axis_tdata
);
    import bsc_pkg::*;

    logic [DUTY_W-1:0]   r_start_limit;
    logic                r_in_valid;
    logic [2:0]          r_in_hall;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;
    t_state              r_state;
    t_result             w_result;
    logic                w_advance;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    bsc_step u_step (
        .i_hall        (r_in_hall),
        .i_sample      (r_in_sample),
        .i_start_limit (r_start_limit),
        .i_state       (r_state),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_limit <= START_LIMIT_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_start_limit <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid       <= 1'b1;
                r_state.armed     <= w_result.armed;
                r_state.pwm_phase <= w_result.pwm_phase;
                r_state.levels    <= w_result.levels;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_hall   <= i_s_axis_tdata[2:0];
            r_in_sample <= i_s_axis_tdata[12:3];
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.armed, r_out.duty, r_out.levels,
                              r_out.pwm_phase, r_out.shutdown};

    a_armed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |=> r_state.armed)
        else $error("armed flag dropped without reset");

    a_unarmed_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.armed) |-> (r_out.shutdown == LINE_NONE))
        else $error("shutdown line driven while unarmed");

    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out.shutdown))
        else $error("more than one shutdown line driven");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready)
            |=> (r_in_valid && $stable(r_in_hall) && $stable(r_in_sample)))
        else $error("pending tick lost during output stall");

    a_state_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.armed == r_state.armed && r_out.levels == r_state.levels))
        else $error("held state differs from reported result");

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int STUCK_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_TICKS  = 270;

    typedef struct packed {
        logic [2:0] shutdown;
        logic [1:0] phase;
        logic [2:0] levels;
        logic [6:0] duty;
        logic       armed;
    } t_drive_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;

    logic        tx_idle = 1'b1;
    logic        rx_idle = 1'b1;
    int          rx_stall_left = 0;
    int          stuck_cycles = 0;

    logic        mdl_armed = 1'b0;
    logic [1:0]  mdl_phase = PHASE_NONE;
    logic [2:0]  mdl_levels = LINE_NONE;
    logic [6:0]  mdl_limit = START_LIMIT_RST;

    t_drive_word expected_drive[$];
    int          err_count = 0;
    int          ticks_sent = 0;
    int          results_seen = 0;
    int          driven_steps = 0;
    int          limit_writes = 0;

    logic [2:0]  hall_ring [6] = '{HALL_STEP1, HALL_STEP2, HALL_STEP3,
                                   HALL_STEP4, HALL_STEP5, HALL_STEP6};

    bldc_six_step_commutator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_drive_word commutate_tick(input logic [2:0] hall,
                                                   input logic [9:0] sample);
        t_drive_word w;
        int          scaled;
        scaled = (int'(sample) * ((1 << DUTY_W) - 1)) / int'(SAMPLE_FULL);
        w.shutdown = LINE_NONE;
        w.duty = scaled[6:0];
        if (!mdl_armed) begin
            if (scaled < int'(mdl_limit)) mdl_armed = 1'b1;
        end else if (scaled != 0) begin
            case (hall)
                HALL_STEP1: begin
                    w.shutdown = LINE_A; mdl_phase = PHASE_B; mdl_levels = LINE_B;
                end
                HALL_STEP2: begin
                    w.shutdown = LINE_A; mdl_phase = PHASE_C; mdl_levels = LINE_C;
                end
                HALL_STEP3: begin
                    w.shutdown = LINE_B; mdl_phase = PHASE_C; mdl_levels = LINE_C;
                end
                HALL_STEP4: begin
                    w.shutdown = LINE_B; mdl_phase = PHASE_A; mdl_levels = LINE_A;
                end
                HALL_STEP5: begin
                    w.shutdown = LINE_C; mdl_phase = PHASE_A; mdl_levels = LINE_A;
                end
                HALL_STEP6: begin
                    w.shutdown = LINE_C; mdl_phase = PHASE_B;
                    mdl_levels = mdl_levels & LINE_B;
                end
                default: ;
            endcase
        end
        w.phase = mdl_phase;
        w.levels = mdl_levels;
        w.armed = mdl_armed;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 100)
            $display("tb_top: mismatch in %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        err_count++;
    endtask

    // Results are checked before new ticks are predicted, so a result appearing in the
    // same cycle as its tick could never be compared against its own prediction.
    always @(posedge i_clk) begin : result_check
        t_drive_word want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_drive.size() == 0) begin
                    report_mismatch("unexpected transfer", int'(o_m_axis_tdata), 0);
                end else begin
                    want = expected_drive.pop_front();
                    if (o_m_axis_tdata[2:0] != want.shutdown)
                        report_mismatch("shutdown_lines", int'(o_m_axis_tdata[2:0]),
                                        int'(want.shutdown));
                    if (o_m_axis_tdata[4:3] != want.phase)
                        report_mismatch("pwm_phase", int'(o_m_axis_tdata[4:3]),
                                        int'(want.phase));
                    if (o_m_axis_tdata[7:5] != want.levels)
                        report_mismatch("input_levels", int'(o_m_axis_tdata[7:5]),
                                        int'(want.levels));
                    if (o_m_axis_tdata[14:8] != want.duty)
                        report_mismatch("duty", int'(o_m_axis_tdata[14:8]),
                                        int'(want.duty));
                    if (o_m_axis_tdata[15] != want.armed)
                        report_mismatch("armed", int'(o_m_axis_tdata[15]),
                                        int'(want.armed));
                    if (want.shutdown != LINE_NONE) driven_steps++;
                end
                results_seen++;
            end
            if (s_valid && o_s_axis_tready)
                expected_drive.push_back(commutate_tick(s_data[2:0], s_data[12:3]));
        end
    end

    always @(posedge i_clk) begin : rx_side
        int draw;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rx_stall_left <= 0;
        end else if (m_ready && o_m_axis_tvalid) begin
            draw = rx_idle ? $urandom_range(0, 8) : 0;
            m_ready <= (draw == 0);
            rx_stall_left <= (draw > 0) ? draw - 1 : 0;
        end else if (!m_ready) begin
            if (rx_stall_left == 0) m_ready <= 1'b1;
            else rx_stall_left <= rx_stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: no transfer for %0d cycles", STUCK_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_tick(input logic [2:0] hall, input logic [9:0] sample);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {3'b000, sample, hall};
        do @(posedge i_clk); while (!o_s_axis_tready);
        ticks_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_limit(input logic [6:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        mdl_limit = value;
        limit_writes++;
    endtask

    // The block can arm only once per reset, so the interlock is covered first.
    task automatic test_unarmed_interlock();
        send_tick(HALL_STEP1, 10'd323);
        send_tick(HALL_STEP3, 10'd1023);
        send_tick(3'd0, 10'd700);
        write_start_limit(7'd0);
        send_tick(HALL_STEP2, 10'd0);
        send_tick(3'd7, 10'd512);
        write_start_limit(7'd127);
        send_tick(HALL_STEP4, 10'd1023);
        write_start_limit(START_LIMIT_RST);
        send_tick(HALL_STEP5, 10'd322);
    endtask

    task automatic test_step_table();
        send_tick(HALL_STEP1, 10'd600);
        send_tick(HALL_STEP2, 10'd1023);
        send_tick(HALL_STEP3, 10'd9);
        send_tick(HALL_STEP4, 10'd450);
        send_tick(HALL_STEP5, 10'd200);
        send_tick(HALL_STEP6, 10'd800);
        send_tick(HALL_STEP1, 10'd300);
        send_tick(HALL_STEP6, 10'd301);
    endtask

    task automatic test_hold_cases();
        send_tick(3'd0, 10'd500);
        send_tick(3'd7, 10'd900);
        send_tick(HALL_STEP2, 10'd8);
        send_tick(HALL_STEP4, 10'd0);
    endtask

    task automatic test_random_commutation();
        int          pos;
        int          dir;
        int          pick;
        int          roll;
        logic [2:0]  hall;
        logic [9:0]  sample;
        pos = 0;
        dir = 1;
        for (int ph = 0; ph < 6; ph++) begin
            write_start_limit(7'($urandom_range(0, 127)));
            tx_idle = (ph != 1) && (ph != 3);
            rx_idle = (ph != 1) && (ph != 2);
            dir = $urandom_range(0, 1) ? 1 : 5;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) pos = (pos + dir) % 6;
                else if (pick < 76) dir = 6 - dir;
                hall = hall_ring[pos];
                if (pick >= 94) hall = 3'($urandom_range(0, 7));
                else if (pick >= 88) hall = $urandom_range(0, 1) ? 3'd7 : 3'd0;
                roll = $urandom_range(0, 99);
                if (roll < 85) sample = 10'($urandom_range(9, 1023));
                else if (roll < 95) sample = 10'($urandom_range(0, 8));
                else sample = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                send_tick(hall, sample);
                if (k == PHASE_TICKS / 2) drain_results();
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unarmed_interlock();
        test_step_table();
        test_hold_cases();
        test_random_commutation();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d ticks sent, %0d results checked, %0d with a step driven",
                 ticks_sent, results_seen, driven_steps);
        $display("tb_top: %0d start_limit writes, %0d mismatches", limit_writes, err_count);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/bsc_pkg.sv
rtl/bsc_step.sv
rtl/bldc_six_step_commutator_top.sv
tb/tb_top.sv
